/* hdl/msbw_pkg.sv */
package msbw_pkg;

    localparam int MAX_FIELD_BITS = 30;
    localparam int MAX_RUN_BYTES  = 5;
    localparam int QUEUE_DEPTH    = 2;
    localparam int WORD_W         = 40;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_ALIGN = 2'd1,
        REQ_START = 2'd2
    } req_type_t;

    typedef struct packed {
        logic [MAX_RUN_BYTES-1:0][7:0] run_bytes;
        logic [2:0]                    count;
        logic                          rejected;
        logic [3:0]                    stuff;
        logic [31:0]                   total;
    } run_desc_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

endpackage

/* hdl/msb_first_bit_writer_with_start_codes.sv */
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    req_type, field_value, field_length, start_code_byte
// m_        out  m_valid/m_ready    out_byte, byte_valid, last_of_run, rejected,
//                                   stuff_length, total_bits
//
// A request is accepted and packed into a run of 0 to 5 bytes.
// Each run yields 1 to 5 results, one per cycle while m_ready is high, from a two-entry run queue.
// Sustained rate is set by the byte drain: one result per cycle while m_ready is high.
// aresetn (synchronous) clears the bit position, partial byte, count and queue.
// s_ready drops only while the run queue is full; a stall on m_ holds the byte.
module msb_first_bit_writer_with_start_codes (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [29:0] s_field_value,
    input  logic [4:0]  s_field_length,
    input  logic [7:0]  s_start_code_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_last_of_run,
    output logic        m_rejected,
    output logic [3:0]  m_stuff_length,
    output logic [31:0] m_total_bits
);
    import msbw_pkg::*;

    run_desc_t   wr_desc;
    run_desc_t   head;
    queue_ctrl_t ctrl;
    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;

    assign ctrl.push = q_push;
    assign ctrl.pop  = q_pop;

    msbw_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_field_value     (s_field_value),
        .s_field_length    (s_field_length),
        .s_start_code_byte (s_start_code_byte),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_desc            (wr_desc)
    );

    msbw_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .wr_desc (wr_desc),
        .rd_desc (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    msbw_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_last_of_run  (m_last_of_run),
        .m_rejected     (m_rejected),
        .m_stuff_length (m_stuff_length),
        .m_total_bits   (m_total_bits)
    );

endmodule

/* hdl/msbw_front.sv */
module msbw_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic [29:0]         s_field_value,
    input  logic [4:0]          s_field_length,
    input  logic [7:0]          s_start_code_byte,
    input  logic                q_full,
    output logic                q_push,
    output msbw_pkg::run_desc_t q_desc
);
    import msbw_pkg::*;

    logic [7:0]  partial_reg, partial_next;
    logic [2:0]  offset_reg, offset_next;
    logic [31:0] total_reg, total_next;

    logic [5:0]                    sum;
    logic [5:0]                    shamt;
    logic [29:0]                   masked;
    logic [WORD_W-1:0]             word;
    logic [MAX_RUN_BYTES-1:0][7:0] wbytes;
    logic [3:0]                    pad;
    run_desc_t                     desc;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign q_desc  = desc;

    always_comb begin
        sum    = {3'd0, offset_reg} + {1'b0, s_field_length};
        shamt  = 6'(WORD_W) - sum;
        masked = s_field_value & ~({30{1'b1}} << s_field_length);
        word   = {partial_reg, 32'd0} | ({10'd0, masked} << shamt);
        for (int k = 0; k < MAX_RUN_BYTES; k++) begin
            wbytes[k] = word[WORD_W-1-8*k -: 8];
        end
        pad = (offset_reg != 3'd0) ? (4'd8 - {1'b0, offset_reg}) : 4'd0;

        partial_next   = partial_reg;
        offset_next    = offset_reg;
        total_next     = total_reg;
        desc.run_bytes = '0;
        desc.count     = 3'd0;
        desc.rejected  = 1'b0;
        desc.stuff     = 4'd0;

        case (s_req_type)
            REQ_WRITE: begin
                if (s_field_length > 5'(MAX_FIELD_BITS)) begin
                    desc.rejected = 1'b1;
                end else begin
                    desc.run_bytes = wbytes;
                    desc.count     = sum[5:3];
                    partial_next   = wbytes[sum[5:3]];
                    offset_next    = sum[2:0];
                    total_next     = total_reg + {27'd0, s_field_length};
                end
            end
            REQ_ALIGN: begin
                desc.run_bytes[0] = partial_reg | (8'h80 >> offset_reg);
                desc.count        = 3'd1;
                desc.stuff        = 4'd8 - {1'b0, offset_reg};
                partial_next      = 8'd0;
                offset_next       = 3'd0;
                total_next        = total_reg + {28'd0, desc.stuff};
            end
            REQ_START: begin
                if (offset_reg != 3'd0) begin
                    desc.run_bytes = {s_start_code_byte, 8'h01, 8'h00, 8'h00, partial_reg};
                    desc.count     = 3'd5;
                end else begin
                    desc.run_bytes = {8'h00, s_start_code_byte, 8'h01, 8'h00, 8'h00};
                    desc.count     = 3'd4;
                end
                partial_next = 8'd0;
                offset_next  = 3'd0;
                total_next   = total_reg + {28'd0, pad} + 32'd32;
            end
            default: begin
            end
        endcase
        desc.total = total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= 8'd0;
            offset_reg  <= 3'd0;
            total_reg   <= 32'd0;
        end else if (q_push) begin
            partial_reg <= partial_next;
            offset_reg  <= offset_next;
            total_reg   <= total_next;
        end
    end

endmodule

/* hdl/msbw_queue.sv */
module msbw_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  msbw_pkg::queue_ctrl_t ctrl,
    input  msbw_pkg::run_desc_t   wr_desc,
    output msbw_pkg::run_desc_t   rd_desc,
    output logic                  full,
    output logic                  empty
);
    import msbw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    run_desc_t mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_desc = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctrl.pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop) begin
            count_next = count_reg + 1'b1;
        end else if (!ctrl.push && ctrl.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |-> !full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |-> !empty) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* hdl/msbw_back.sv */
module msbw_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  msbw_pkg::run_desc_t head,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_byte_valid,
    output logic                m_last_of_run,
    output logic                m_rejected,
    output logic [3:0]          m_stuff_length,
    output logic [31:0]         m_total_bits
);
    import msbw_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic [2:0] last_idx;

    assign last_idx       = (head.count == 3'd0) ? 3'd0 : head.count - 3'd1;
    assign m_valid        = !q_empty;
    assign m_byte_valid   = (head.count != 3'd0);
    assign m_out_byte     = m_byte_valid ? head.run_bytes[idx_reg] : 8'd0;
    assign m_last_of_run  = (idx_reg == last_idx);
    assign m_rejected     = head.rejected;
    assign m_stuff_length = head.stuff;
    assign m_total_bits   = head.total;
    assign q_pop          = m_valid && m_ready && m_last_of_run;

    always_comb begin
        idx_next = idx_reg;
        if (m_valid && m_ready) begin
            idx_next = m_last_of_run ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 3'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> m_last_of_run) else $error("empty run not last");
    a_rejected_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rejected) |-> !m_byte_valid) else $error("rejected item with byte");
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid) else $error("run cut short");
    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> idx_reg <= last_idx) else $error("byte index past run");
`endif

endmodule

/* tb/tb_msb_first_bit_writer_with_start_codes.sv */
module tb_msb_first_bit_writer_with_start_codes;
    timeunit 1ns;
    timeprecision 1ps;

    import msbw_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]  out_val;
        logic        has_byte;
        logic        last;
        logic        rej;
        logic [3:0]  stuff;
        logic [31:0] total;
    } stream_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [29:0] s_field_value;
    logic [4:0]  s_field_length;
    logic [7:0]  s_start_code_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_last_of_run;
    logic        m_rejected;
    logic [3:0]  m_stuff_length;
    logic [31:0] m_total_bits;

    stream_result_t expected_bytes[$];
    stream_result_t head_result;
    int             mismatch_count = 0;
    bit             sender_idling  = 1'b1;
    bit             recv_idling    = 1'b1;

    logic [7:0]  frag_byte        = 8'h00;
    int          frag_fill        = 0;
    logic [31:0] stream_bits      = 32'd0;
    logic [31:0] stuff_bits_total = 32'd0;

    msb_first_bit_writer_with_start_codes uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_field_value     (s_field_value),
        .s_field_length    (s_field_length),
        .s_start_code_byte (s_start_code_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_byte_valid      (m_byte_valid),
        .m_last_of_run     (m_last_of_run),
        .m_rejected        (m_rejected),
        .m_stuff_length    (m_stuff_length),
        .m_total_bits      (m_total_bits)
    );

    always #10 aclk = ~aclk;

    task automatic pack_request(input logic [1:0] rt, input logic [29:0] v,
                                input logic [4:0] len, input logic [7:0] code);
        logic [7:0]     run[$];
        logic           rej;
        logic [3:0]     stuff;
        int             i;
        stream_result_t r;
        rej   = 1'b0;
        stuff = 4'd0;
        case (rt)
            REQ_WRITE: begin
                if (len > MAX_FIELD_BITS) begin
                    rej = 1'b1;
                end else begin
                    for (i = len; i > 0; i--) begin
                        if (v[i-1]) frag_byte[7-frag_fill] = 1'b1;
                        frag_fill++;
                        stream_bits++;
                        if (frag_fill == 8) begin
                            run.push_back(frag_byte);
                            frag_byte = 8'h00;
                            frag_fill = 0;
                        end
                    end
                end
            end
            REQ_ALIGN: begin
                stuff = 4'(8 - frag_fill);
                frag_byte[7-frag_fill] = 1'b1;
                stream_bits      += 32'(stuff);
                stuff_bits_total += 32'(stuff);
                run.push_back(frag_byte);
                frag_byte = 8'h00;
                frag_fill = 0;
            end
            REQ_START: begin
                if (frag_fill != 0) begin
                    stream_bits += 32'(8 - frag_fill);
                    run.push_back(frag_byte);
                    frag_byte = 8'h00;
                    frag_fill = 0;
                end
                run.push_back(8'h00);
                run.push_back(8'h00);
                run.push_back(8'h01);
                run.push_back(code);
                stream_bits += 32'd32;
            end
            default: ;
        endcase
        r.rej   = rej;
        r.stuff = stuff;
        r.total = stream_bits;
        if (run.size() == 0) begin
            r.out_val  = 8'h00;
            r.has_byte = 1'b0;
            r.last     = 1'b1;
            expected_bytes.push_back(r);
        end else begin
            for (i = 0; i < run.size(); i++) begin
                r.out_val  = run[i];
                r.has_byte = 1'b1;
                r.last     = (i == run.size() - 1);
                expected_bytes.push_back(r);
            end
        end
    endtask

    task automatic send_req(input logic [1:0] rt, input logic [29:0] v,
                            input logic [4:0] len, input logic [7:0] code);
        if (sender_idling && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_req_type        <= rt;
        s_field_value     <= v;
        s_field_length    <= len;
        s_start_code_byte <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pack_request(rt, v, len, code);
    endtask

    task automatic send_random_req();
        int          pick;
        logic [1:0]  rt;
        logic [29:0] v;
        logic [4:0]  len;
        logic [7:0]  code;
        pick = $urandom_range(0, 99);
        if (pick < 62)      rt = REQ_WRITE;
        else if (pick < 78) rt = REQ_ALIGN;
        else if (pick < 95) rt = REQ_START;
        else                rt = REQ_UNUSED;
        pick = $urandom_range(0, 15);
        if (pick == 0)      len = 5'd31;
        else if (pick < 5)  len = 5'($urandom_range(24, 30));
        else                len = 5'($urandom_range(0, 30));
        v    = 30'($urandom);
        code = 8'($urandom);
        send_req(rt, v, len, code);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_bytes.size() == 0) begin
                $error("out_byte: expected none, actual %0h", m_out_byte);
                mismatch_count++;
            end else begin
                head_result = expected_bytes.pop_front();
                check_field("out_byte", 32'(head_result.out_val), 32'(m_out_byte));
                check_field("byte_valid", 32'(head_result.has_byte), 32'(m_byte_valid));
                check_field("last_of_run", 32'(head_result.last), 32'(m_last_of_run));
                check_field("rejected", 32'(head_result.rej), 32'(m_rejected));
                check_field("stuff_length", 32'(head_result.stuff), 32'(m_stuff_length));
                check_field("total_bits", head_result.total, m_total_bits);
            end
        end
    end

    initial begin
        m_ready <= 1'b0;
        repeat (11) @(posedge aclk);
        forever begin
            if (recv_idling && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    task automatic test_writes();
        send_req(REQ_WRITE, 30'h0000_0000, 5'd0, 8'h00);
        send_req(REQ_WRITE, 30'h3FFF_FFFF, 5'd1, 8'hFF);
        send_req(REQ_WRITE, 30'h3FFF_FFFF, 5'd30, 8'h00);
        send_req(REQ_WRITE, 30'h3FFF_FFFF, 5'd31, 8'hFF);
        send_req(REQ_WRITE, 30'h0000_0000, 5'd30, 8'h00);
        send_req(REQ_WRITE, 30'h2AAA_AAAA, 5'd30, 8'h00);
        send_req(REQ_WRITE, 30'h1555_5555, 5'd30, 8'h00);
        send_req(REQ_WRITE, 30'h0000_0055, 5'd7, 8'h00);
    endtask

    task automatic test_align();
        send_req(REQ_ALIGN, 30'h0, 5'd0, 8'h00);
        send_req(REQ_ALIGN, 30'h3FFF_FFFF, 5'd31, 8'hFF);
        send_req(REQ_WRITE, 30'h1, 5'd1, 8'h00);
        send_req(REQ_ALIGN, 30'h0, 5'd0, 8'h00);
        send_req(REQ_WRITE, 30'h7F, 5'd7, 8'h00);
        send_req(REQ_ALIGN, 30'h0, 5'd0, 8'h00);
    endtask

    task automatic test_start_codes();
        send_req(REQ_START, 30'h0, 5'd0, 8'hB3);
        send_req(REQ_WRITE, 30'h5, 5'd3, 8'h00);
        send_req(REQ_START, 30'h3FFF_FFFF, 5'd31, 8'hFF);
        send_req(REQ_WRITE, 30'h3F, 5'd6, 8'h00);
        send_req(REQ_START, 30'h0, 5'd0, 8'h00);
    endtask

    task automatic test_unused_selector();
        send_req(REQ_WRITE, 30'h2, 5'd2, 8'h00);
        send_req(REQ_UNUSED, 30'h3FFF_FFFF, 5'd30, 8'hFF);
        send_req(REQ_ALIGN, 30'h0, 5'd0, 8'h00);
        send_req(REQ_UNUSED, 30'h0, 5'd0, 8'h00);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_random_req();
    endtask

    task automatic test_back_to_back(input int count);
        sender_idling = 1'b0;
        recv_idling   = 1'b0;
        repeat (count) send_random_req();
    endtask

    initial begin
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_req_type        <= REQ_WRITE;
        s_field_value     <= 30'h0;
        s_field_length    <= 5'd0;
        s_start_code_byte <= 8'h00;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_writes();
        test_align();
        test_start_codes();
        test_unused_selector();
        test_random_mix(430);
        test_back_to_back(50);

        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
